@@ design/ncc_stereo_disparity_search_top_defines.svh @@
// assertion macros for the ncc stereo disparity search block
`ifndef NCC_STEREO_DISPARITY_SEARCH_TOP_DEFINES_SVH
`define NCC_STEREO_DISPARITY_SEARCH_TOP_DEFINES_SVH

// property checked only outside reset
`define NCCS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also looks at the reset itself
`define NCCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/nccs_pkg.sv @@
// shared constants, register codes and width helpers of the ncc stereo block
package nccs_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF     = 1024;
  localparam int MAX_HEIGHT_DEF    = 4096;
  localparam int WINDOW_RADIUS_DEF = 4;
  localparam int DISP_RANGE_DEF    = 32;

  // port widths
  localparam int PIX_W       = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // configuration register reset values
  localparam logic [10:0]        IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [12:0]        IMAGE_HEIGHT_RST = 13'd480;
  localparam logic signed [6:0]  DISP_LOW_RST     = -7'sd30;
  localparam logic signed [6:0]  DISP_HIGH_RST    = -7'sd7;
  localparam logic signed [15:0] THRESHOLD_RST    = 16'sd31130;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_DISP_LOW     = 3'd2,
    REG_DISP_HIGH    = 3'd3,
    REG_THRESHOLD    = 3'd4
  } cfg_reg_t;

  // pixels in one square window
  function automatic int pix_count(input int radius);
    return (2 * radius + 1) * (2 * radius + 1);
  endfunction

  // width of a window sum of pixels
  function automatic int sum_w(input int radius);
    return $clog2(pix_count(radius) * 255 + 1);
  endfunction

  // width of a window sum of pixel products
  function automatic int sq_sum_w(input int radius);
    return $clog2(pix_count(radius) * 65025 + 1);
  endfunction

  // width of the pixel count itself
  function automatic int cnt_w(input int radius);
    return $clog2(pix_count(radius) + 1);
  endfunction

endpackage

@@ design/nccs_cell.sv @@
// one disparity cell: window sums for one shift, left pixel passed on to the next cell
module nccs_cell #(
  parameter int WINDOW_RADIUS = nccs_pkg::WINDOW_RADIUS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          clr,
  input  logic [nccs_pkg::PIX_W-1:0]                    l_pix_i,
  input  logic                                          l_vld_i,
  input  logic [nccs_pkg::PIX_W-1:0]                    r_pix_i,
  input  logic                                          r_vld_i,
  output logic [nccs_pkg::PIX_W-1:0]                    l_pix_o,
  output logic                                          l_vld_o,
  output logic [nccs_pkg::sum_w(WINDOW_RADIUS)-1:0]     s1_o,
  output logic [nccs_pkg::sum_w(WINDOW_RADIUS)-1:0]     s2_o,
  output logic [nccs_pkg::sq_sum_w(WINDOW_RADIUS)-1:0]  s11_o,
  output logic [nccs_pkg::sq_sum_w(WINDOW_RADIUS)-1:0]  s22_o,
  output logic [nccs_pkg::sq_sum_w(WINDOW_RADIUS)-1:0]  s12_o
);

  localparam int SW1 = nccs_pkg::sum_w(WINDOW_RADIUS);
  localparam int SW2 = nccs_pkg::sq_sum_w(WINDOW_RADIUS);

  logic [nccs_pkg::PIX_W-1:0] l_pix_r;
  logic                       l_vld_r;
  logic [SW1-1:0]             s1_r, s2_r;
  logic [SW2-1:0]             s11_r, s22_r, s12_r;
  logic [15:0]                p11, p22, p12;
  logic                       hit;

  // products of the pixel pair in this cell
  always_comb begin
    p11 = 16'(l_pix_i) * 16'(l_pix_i);
    p22 = 16'(r_pix_i) * 16'(r_pix_i);
    p12 = 16'(l_pix_i) * 16'(r_pix_i);
    hit = l_vld_i && r_vld_i;
  end

  // left pixel shift to the neighbour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_vld_r <= 1'b0;
    end else if (clr) begin
      l_vld_r <= 1'b0;
    end else begin
      l_vld_r <= l_vld_i;
    end
    l_pix_r <= l_pix_i;
  end

  // window sums
  always_ff @(posedge clk) begin
    if (clr) begin
      s1_r  <= '0;
      s2_r  <= '0;
      s11_r <= '0;
      s22_r <= '0;
      s12_r <= '0;
    end else if (hit) begin
      s1_r  <= s1_r + SW1'(l_pix_i);
      s2_r  <= s2_r + SW1'(r_pix_i);
      s11_r <= s11_r + SW2'(p11);
      s22_r <= s22_r + SW2'(p22);
      s12_r <= s12_r + SW2'(p12);
    end
  end

  assign l_pix_o = l_pix_r;
  assign l_vld_o = l_vld_r;
  assign s1_o    = s1_r;
  assign s2_o    = s2_r;
  assign s11_o   = s11_r;
  assign s22_o   = s22_r;
  assign s12_o   = s12_r;

endmodule

@@ design/nccs_score.sv @@
// shared scorer: covariance, variances, bit-serial square root and divide to a q1.15 ncc
module nccs_score #(
  parameter int WINDOW_RADIUS = nccs_pkg::WINDOW_RADIUS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  logic [nccs_pkg::sum_w(WINDOW_RADIUS)-1:0]     s1_i,
  input  logic [nccs_pkg::sum_w(WINDOW_RADIUS)-1:0]     s2_i,
  input  logic [nccs_pkg::sq_sum_w(WINDOW_RADIUS)-1:0]  s11_i,
  input  logic [nccs_pkg::sq_sum_w(WINDOW_RADIUS)-1:0]  s22_i,
  input  logic [nccs_pkg::sq_sum_w(WINDOW_RADIUS)-1:0]  s12_i,
  output logic                                          done,
  output logic signed [15:0]                            score
);

  localparam int NPIX  = nccs_pkg::pix_count(WINDOW_RADIUS);
  localparam int SW1   = nccs_pkg::sum_w(WINDOW_RADIUS);
  localparam int SW2   = nccs_pkg::sq_sum_w(WINDOW_RADIUS);
  localparam int NW    = nccs_pkg::cnt_w(WINDOW_RADIUS);
  localparam int PW    = (NW + SW2 > 2 * SW1) ? NW + SW2 : 2 * SW1;
  localparam int SQI   = PW + 1;
  localparam int SQW   = 2 * SQI;
  localparam int RTW   = SQI + 1;
  localparam int EPS_I = (NPIX * NPIX + 5) / 10;
  localparam int ITW   = $clog2(SQI + 1);

  typedef enum logic [8:0] {
    SC_IDLE = 9'b000000001,
    SC_MUL1 = 9'b000000010,
    SC_MUL2 = 9'b000000100,
    SC_MUL3 = 9'b000001000,
    SC_MUL4 = 9'b000010000,
    SC_VAR  = 9'b000100000,
    SC_SQRT = 9'b001000000,
    SC_DIV  = 9'b010000000,
    SC_DONE = 9'b100000000
  } sc_state_t;

  sc_state_t         state_r, state_nxt;
  logic [SW1-1:0]    s1_r, s2_r;
  logic [SW2-1:0]    s11_r, s22_r, s12_r;
  logic [PW-1:0]     prod_r, nt_r, v1_r, v2_r;
  logic signed [PW:0] c_r;
  logic [PW:0]       abs_c;
  logic [SQW:0]      rem_r, root_r, trial;
  logic [SQW-1:0]    bit_r;
  logic [ITW-1:0]    it_r;
  logic [RTW-1:0]    drem_r, rem2, rt;
  logic [15:0]       q_r;
  logic              lsb_r;

  // magnitude of the covariance and divisor
  always_comb begin
    abs_c = c_r[PW] ? (PW+1)'(-c_r) : (PW+1)'(c_r);
    trial = root_r + (SQW+1)'(bit_r);
    rt    = (root_r[SQI-1:0] == '0) ? RTW'(1) : RTW'(root_r[SQI-1:0]);
    rem2  = {drem_r[SQI-1:0], lsb_r};
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SC_IDLE: if (start) state_nxt = SC_MUL1;
      SC_MUL1: state_nxt = SC_MUL2;
      SC_MUL2: state_nxt = SC_MUL3;
      SC_MUL3: state_nxt = SC_MUL4;
      SC_MUL4: state_nxt = SC_VAR;
      SC_VAR:  state_nxt = SC_SQRT;
      SC_SQRT: if (it_r == ITW'(SQI - 1)) state_nxt = SC_DIV;
      SC_DIV:  if (it_r == ITW'(15)) state_nxt = SC_DONE;
      SC_DONE: state_nxt = SC_IDLE;
      default: state_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath, sums multiplied out in the MUL steps, then square root and divide
  always_ff @(posedge clk) begin
    case (state_r)
      SC_IDLE: begin
        s1_r  <= s1_i;
        s2_r  <= s2_i;
        s11_r <= s11_i;
        s22_r <= s22_i;
        s12_r <= s12_i;
      end
      SC_MUL1: begin
        prod_r <= PW'(s1_r) * PW'(s2_r);
        nt_r   <= PW'(NPIX) * PW'(s12_r);
      end
      SC_MUL2: begin
        c_r    <= signed'({1'b0, nt_r}) - signed'({1'b0, prod_r});
        prod_r <= PW'(s1_r) * PW'(s1_r);
        nt_r   <= PW'(NPIX) * PW'(s11_r);
      end
      SC_MUL3: begin
        v1_r   <= nt_r - prod_r;
        prod_r <= PW'(s2_r) * PW'(s2_r);
        nt_r   <= PW'(NPIX) * PW'(s22_r);
      end
      SC_MUL4: begin
        v2_r <= nt_r - prod_r;
      end
      SC_VAR: begin
        rem_r  <= (SQW+1)'(v1_r) * (SQW+1)'(v2_r) + (SQW+1)'(EPS_I);
        root_r <= '0;
        bit_r  <= SQW'(1) << (SQW - 2);
        it_r   <= '0;
        drem_r <= RTW'(abs_c >> 1);
        lsb_r  <= abs_c[0];
        q_r    <= '0;
      end
      SC_SQRT: begin
        if (rem_r >= trial) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + (SQW+1)'(bit_r);
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        it_r  <= (it_r == ITW'(SQI - 1)) ? '0 : it_r + ITW'(1);
      end
      SC_DIV: begin
        if (rem2 >= rt) begin
          drem_r <= rem2 - rt;
          q_r    <= {q_r[14:0], 1'b1};
        end else begin
          drem_r <= rem2;
          q_r    <= {q_r[14:0], 1'b0};
        end
        lsb_r <= 1'b0;
        it_r  <= it_r + ITW'(1);
      end
      default: begin
      end
    endcase
  end

  // sign and saturation
  always_comb begin
    if (c_r[PW]) begin
      score = signed'(-q_r);
    end else if (q_r[15]) begin
      score = 16'sh7fff;
    end else begin
      score = signed'(q_r);
    end
  end

  assign done = (state_r == SC_DONE);

endmodule

@@ design/ncc_stereo_disparity_search_top.sv @@
// top level of the ncc block-matching stereo disparity search
// Takes one left/right pixel pair per beat in raster order and returns, for each
// window centre with a full window, the disparity with the highest zero-mean ncc
// score above the threshold, the earliest one on a tie. A pixel that completes no
// window does not hold the input. A pixel that completes a window holds the input
// while the row of disparity cells sums the window (one pixel pair per cycle
// through the line store read ports), then while each disparity slot is visited in
// turn and each disparity in range is scored by the shared scorer's bit-serial
// square root and divide, then while the result is handed over. Line stores need
// no clearing after reset.
module ncc_stereo_disparity_search_top #(
  parameter int MAX_WIDTH     = nccs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = nccs_pkg::MAX_HEIGHT_DEF,
  parameter int WINDOW_RADIUS = nccs_pkg::WINDOW_RADIUS_DEF,
  parameter int DISP_RANGE    = nccs_pkg::DISP_RANGE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // left_pixel [7:0], right_pixel [15:8]
  input  logic [nccs_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // centre_column [9:0], centre_row [21:10], disparity [29:22],
  // best_score [45:30], zero [47:46]
  output logic [nccs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // found [0]
  output logic                                out_tuser,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nccs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nccs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SIDE  = 2 * WINDOW_RADIUS + 1;
  localparam int R2    = 2 * WINDOW_RADIUS;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WEW   = $clog2(MAX_WIDTH + 1);
  localparam int HEW   = $clog2(MAX_HEIGHT + 1);
  localparam int SLW   = $clog2(SIDE);
  localparam int DEPTH = SIDE * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = (DISP_RANGE > 1) ? $clog2(DISP_RANGE) : 1;
  localparam int TN    = SIDE + DISP_RANGE - 1;
  localparam int TW    = $clog2(TN);
  localparam int CSW   = ((CW > 8) ? CW : 8) + 3;
  localparam int SW1   = nccs_pkg::sum_w(WINDOW_RADIUS);
  localparam int SW2   = nccs_pkg::sq_sum_w(WINDOW_RADIUS);
  localparam int PW    = nccs_pkg::PIX_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FEED  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_SCORE = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [10:0]        img_w_r;
  logic [12:0]        img_h_r;
  logic signed [6:0]  dlo_r, dhi_r;
  logic signed [15:0] thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= nccs_pkg::IMAGE_WIDTH_RST;
      img_h_r <= nccs_pkg::IMAGE_HEIGHT_RST;
      dlo_r   <= nccs_pkg::DISP_LOW_RST;
      dhi_r   <= nccs_pkg::DISP_HIGH_RST;
      thr_r   <= nccs_pkg::THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nccs_pkg::REG_IMAGE_WIDTH:  img_w_r <= cfg_data[10:0];
        nccs_pkg::REG_IMAGE_HEIGHT: img_h_r <= cfg_data[12:0];
        nccs_pkg::REG_DISP_LOW:     dlo_r   <= signed'(cfg_data[6:0]);
        nccs_pkg::REG_DISP_HIGH:    dhi_r   <= signed'(cfg_data[6:0]);
        nccs_pkg::REG_THRESHOLD:    thr_r   <= signed'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // frame size in use
  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;

  always_comb begin
    if (img_w_r == '0) begin
      w_eff = WEW'(1);
    end else if (int'(img_w_r) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(img_w_r);
    end
    if (img_h_r == '0) begin
      h_eff = HEW'(1);
    end else if (int'(img_h_r) > MAX_HEIGHT) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(img_h_r);
    end
  end

  // raster position of the incoming beat
  logic [CW-1:0]  col_r;
  logic [RW-1:0]  row_r;
  logic [SLW-1:0] wslot_r;
  logic           acc, has_res, col_last, row_last;

  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    has_res  = (int'(col_r) >= R2) && (int'(row_r) >= R2) &&
               (int'(col_r) < int'(w_eff)) && (int'(row_r) < int'(h_eff));
    col_last = (int'(col_r) + 1 >= int'(w_eff));
    row_last = (int'(row_r) + 1 >= int'(h_eff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      wslot_r <= '0;
    end else if (acc) begin
      if (col_last) begin
        col_r <= '0;
        if (row_last) begin
          row_r   <= '0;
          wslot_r <= '0;
        end else begin
          row_r   <= row_r + RW'(1);
          wslot_r <= (int'(wslot_r) == SIDE - 1) ? '0 : wslot_r + SLW'(1);
        end
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // per-window registers
  logic [CW-1:0]          cx_r, lbase_r;
  logic [RW-1:0]          cy_r;
  logic                   eof_r;
  logic signed [CSW-1:0]  rbase_r;
  logic [DISP_RANGE-1:0]  mask_r, mask_nxt;
  logic [TW-1:0]          t_r;
  logic [SLW-1:0]         krow_r, rslot_r;
  logic [KW-1:0]          kc_r;
  logic signed [15:0]     best_r;
  logic signed [7:0]      bestd_r;
  logic                   found_r;
  logic                   start_win;

  assign start_win = acc && has_res;

  // disparities that are in span, not positive and inside the image
  always_comb begin
    for (int k = 0; k < DISP_RANGE; k++) begin
      mask_nxt[k] = (k <= int'(dhi_r) - int'(dlo_r)) &&
                    (int'(dlo_r) + k <= 0) &&
                    (int'(col_r) - R2 + int'(dlo_r) + k >= 0);
    end
  end

  // line stores and window read ports
  logic [PW-1:0]  lmem [DEPTH];
  logic [PW-1:0]  rmem [DEPTH];
  logic [PW-1:0]  lq_r, rq_r;
  logic [AW-1:0]  wr_addr, l_rd_addr, r_rd_addr;
  logic           fv_r, flv_r;
  int             lcol, rcol;

  always_comb begin
    wr_addr = AW'(int'(wslot_r) * MAX_WIDTH + int'(col_r));
    lcol    = (int'(t_r) < SIDE) ? int'(lbase_r) + int'(t_r) : 0;
    rcol    = int'(rbase_r) + int'(t_r);
    if (rcol < 0 || rcol >= MAX_WIDTH) begin
      rcol = 0;
    end
    l_rd_addr = AW'(int'(rslot_r) * MAX_WIDTH + lcol);
    r_rd_addr = AW'(int'(rslot_r) * MAX_WIDTH + rcol);
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      lmem[wr_addr] <= in_tdata[PW-1:0];
      rmem[wr_addr] <= in_tdata[2*PW-1:PW];
    end
    lq_r <= lmem[l_rd_addr];
    rq_r <= rmem[r_rd_addr];
  end

  // read data valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r  <= 1'b0;
      flv_r <= 1'b0;
    end else begin
      fv_r  <= (state_r == ST_FEED);
      flv_r <= (state_r == ST_FEED) && (int'(t_r) < SIDE);
    end
  end

  // row of disparity cells
  logic [PW-1:0]  lp   [DISP_RANGE];
  logic           lv   [DISP_RANGE];
  logic [SW1-1:0] s1_a [DISP_RANGE];
  logic [SW1-1:0] s2_a [DISP_RANGE];
  logic [SW2-1:0] s11_a [DISP_RANGE];
  logic [SW2-1:0] s22_a [DISP_RANGE];
  logic [SW2-1:0] s12_a [DISP_RANGE];

  for (genvar k = 0; k < DISP_RANGE; k++) begin : g_cell
    logic [PW-1:0] l_in;
    logic          lv_in;
    if (k == 0) begin : g_head
      assign l_in  = lq_r;
      assign lv_in = flv_r;
    end else begin : g_link
      assign l_in  = lp[k-1];
      assign lv_in = lv[k-1];
    end
    nccs_cell #(
      .WINDOW_RADIUS (WINDOW_RADIUS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (start_win),
      .l_pix_i (l_in),
      .l_vld_i (lv_in),
      .r_pix_i (rq_r),
      .r_vld_i (fv_r),
      .l_pix_o (lp[k]),
      .l_vld_o (lv[k]),
      .s1_o    (s1_a[k]),
      .s2_o    (s2_a[k]),
      .s11_o   (s11_a[k]),
      .s22_o   (s22_a[k]),
      .s12_o   (s12_a[k])
    );
  end

  // shared scorer
  logic               sc_start, sc_done;
  logic signed [15:0] sc_score;

  assign sc_start = (state_r == ST_SCORE) && mask_r[kc_r];

  nccs_score #(
    .WINDOW_RADIUS (WINDOW_RADIUS)
  ) u_score (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .s1_i  (s1_a[kc_r]),
    .s2_i  (s2_a[kc_r]),
    .s11_i (s11_a[kc_r]),
    .s22_i (s22_a[kc_r]),
    .s12_i (s12_a[kc_r]),
    .done  (sc_done),
    .score (sc_score)
  );

  // control sequence
  logic out_free, k_last, t_last, row_done;

  always_comb begin
    out_free = !out_tvalid || out_tready;
    k_last   = (int'(kc_r) == DISP_RANGE - 1);
    t_last   = (int'(t_r) == TN - 1);
    row_done = (int'(krow_r) == SIDE - 1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start_win) state_nxt = ST_FEED;
      ST_FEED:  if (t_last && row_done) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_SCORE;
      ST_SCORE: begin
        if (mask_r[kc_r]) begin
          state_nxt = ST_WAIT;
        end else if (k_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_WAIT: begin
        if (sc_done) begin
          state_nxt = k_last ? ST_EMIT : ST_SCORE;
        end
      end
      ST_EMIT:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // window bookkeeping and running best
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cx_r    <= col_r - CW'(WINDOW_RADIUS);
        cy_r    <= row_r - RW'(WINDOW_RADIUS);
        eof_r   <= col_last && row_last;
        lbase_r <= col_r - CW'(R2);
        rbase_r <= CSW'(int'(col_r) - R2 + int'(dlo_r));
        mask_r  <= mask_nxt;
        rslot_r <= (int'(wslot_r) == SIDE - 1) ? '0 : wslot_r + SLW'(1);
        krow_r  <= '0;
        t_r     <= '0;
        kc_r    <= '0;
        best_r  <= thr_r;
        bestd_r <= 8'(int'(dlo_r) - 1);
        found_r <= 1'b0;
      end
      ST_FEED: begin
        if (t_last) begin
          t_r     <= '0;
          krow_r  <= krow_r + SLW'(1);
          rslot_r <= (int'(rslot_r) == SIDE - 1) ? '0 : rslot_r + SLW'(1);
        end else begin
          t_r <= t_r + TW'(1);
        end
      end
      ST_SCORE: begin
        if (!mask_r[kc_r] && !k_last) begin
          kc_r <= kc_r + KW'(1);
        end
      end
      ST_WAIT: begin
        if (sc_done) begin
          if (sc_score > best_r) begin
            best_r  <= sc_score;
            bestd_r <= 8'(int'(dlo_r) + int'(kc_r));
            found_r <= 1'b1;
          end
          if (!k_last) begin
            kc_r <= kc_r + KW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  logic [nccs_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                             out_tuser_r, out_tlast_r, out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_tdata_r <= {2'b00, best_r, bestd_r, 12'(cy_r), 10'(cx_r)};
      out_tuser_r <= found_r;
      out_tlast_r <= eof_r;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_tvalid = out_tvalid_r;

endmodule

@@ design/nccs_checker.sv @@
// port-level checks of the ncc stereo block and their binding
`include "ncc_stereo_disparity_search_top_defines.svh"

module nccs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic [nccs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [nccs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [nccs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [nccs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // reset leaves no result and an open input
  `NCCS_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_tvalid && in_tready, "result or stall after reset")

  // a stalled result beat keeps its contents
  `NCCS_ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result beat changed under stall")

  // a new result only appears while the input is held off
  `NCCS_ASSERT_CLK(a_out_from_busy, $rose(out_tvalid) |-> $past(!in_tready), "result raised while idle")

  // the input closes only after a beat was taken
  `NCCS_ASSERT_CLK(a_busy_after_beat, $fell(in_tready) |-> $past(in_tvalid), "input closed without a beat")

  // a match is never a positive disparity
  `NCCS_ASSERT_CLK(a_found_not_pos, out_tvalid && out_tuser |-> out_tdata[29] || (out_tdata[29:22] == 8'd0), "positive disparity reported")

endmodule

bind ncc_stereo_disparity_search_top nccs_checker u_nccs_checker (.*);

@@ dv/tb_ncc_stereo_disparity_search_top.sv @@
// testbench for the ncc stereo disparity search block: small frames, scored against a local model
`timescale 1ns / 1ps

module tb_ncc_stereo_disparity_search_top;
  import nccs_pkg::*;

  localparam int RAD  = WINDOW_RADIUS_DEF;
  localparam int SIDE = 2 * RAD + 1;
  localparam int NPIX = SIDE * SIDE;
  localparam int SPAN = DISP_RANGE_DEF;
  localparam int ARR  = 32;
  localparam int SETTLE = 3000;

  typedef struct packed {
    logic [9:0]         col;
    logic [11:0]        row;
    logic signed [7:0]  disp;
    logic               found;
    logic signed [15:0] score;
    logic               eof;
  } match_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser, out_tlast, out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // model copy of registers and raster position
  logic [10:0]        img_w_q = IMAGE_WIDTH_RST;
  logic [12:0]        img_h_q = IMAGE_HEIGHT_RST;
  logic signed [6:0]  dlo_q   = DISP_LOW_RST;
  logic signed [6:0]  dhi_q   = DISP_HIGH_RST;
  logic signed [15:0] thr_q   = THRESHOLD_RST;
  int col_pos = 0, row_pos = 0;
  logic [7:0] lpix [0:ARR-1][0:ARR-1];
  logic [7:0] rpix [0:ARR-1][0:ARR-1];
  logic [7:0] frame_l [0:ARR-1][0:ARR-1];
  logic [7:0] frame_r [0:ARR-1][0:ARR-1];

  match_t pending_matches[$];
  int     fail_count = 0;
  bit     calm = 1'b0;
  bit     src_idle_en = 1'b1;
  bit     hold_req = 1'b0;
  bit     hold_done = 1'b0;
  int     hold_cnt = 0;
  int     sink_gap = 0;

  ncc_stereo_disparity_search_top dut (.*);

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // zero-mean ncc of left window at x against right window at x+d, rows r-2R..r
  function automatic int ncc_window_score(input int x, input int r, input int d);
    longint s1, s2, s11, s22, s12, a, b, cv;
    longint unsigned v1, v2, dd, rt, ac, mag;
    int rr;
    s1 = 0; s2 = 0; s11 = 0; s22 = 0; s12 = 0;
    for (int k = 0; k < SIDE; k++) begin
      rr = r - 2 * RAD + k;
      for (int j = 0; j < SIDE; j++) begin
        a = lpix[rr][x - RAD + j];
        b = rpix[rr][x + d - RAD + j];
        s1 += a; s2 += b; s11 += a * a; s22 += b * b; s12 += a * b;
      end
    end
    cv = NPIX * s12 - s1 * s2;
    v1 = NPIX * s11 - s1 * s1;
    v2 = NPIX * s22 - s2 * s2;
    dd = v1 * v2 + (NPIX * NPIX + 5) / 10;
    rt = int_sqrt(dd);
    if (rt == 0) rt = 1;
    ac = (cv < 0) ? -cv : cv;
    mag = (ac << 15) / rt;
    if (mag > 32768) mag = 32768;
    if (cv < 0) return -int'(mag);
    return (mag > 32767) ? 32767 : int'(mag);
  endfunction

  // advance the model by one pixel pair, queue the match it completes
  task automatic predict_pixel(input logic [7:0] lp, input logic [7:0] rp);
    int w, h, x, lo, hi, best, bestd, s;
    bit fnd;
    match_t m;
    w = (img_w_q < 1) ? 1 : ((img_w_q > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(img_w_q));
    h = (img_h_q < 1) ? 1 : ((img_h_q > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(img_h_q));
    if (col_pos < ARR && row_pos < ARR) begin
      lpix[row_pos][col_pos] = lp;
      rpix[row_pos][col_pos] = rp;
    end
    if (col_pos >= 2 * RAD && row_pos >= 2 * RAD && col_pos < w && row_pos < h) begin
      x = col_pos - RAD;
      lo = dlo_q;
      hi = dhi_q;
      if (hi > lo + SPAN - 1) hi = lo + SPAN - 1;
      best = thr_q;
      bestd = lo - 1;
      fnd = 1'b0;
      for (int d = lo; d <= hi; d++) begin
        if (d > 0 || x + d - RAD < 0) continue;
        s = ncc_window_score(x, row_pos, d);
        if (s > best) begin
          best = s; bestd = d; fnd = 1'b1;
        end
      end
      m.col = x;
      m.row = row_pos - RAD;
      m.disp = bestd;
      m.found = fnd;
      m.score = best;
      m.eof = (col_pos == w - 1 && row_pos == h - 1);
      pending_matches.push_back(m);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  // result side: random stalls, one long hold-off, field checks
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_matches.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          fail_count++;
        end else begin
          match_t m;
          m = pending_matches.pop_front();
          if (out_tdata[9:0] !== m.col) begin
            $error("centre_column exp %0d got %0d", m.col, out_tdata[9:0]); fail_count++;
          end
          if (out_tdata[21:10] !== m.row) begin
            $error("centre_row exp %0d got %0d", m.row, out_tdata[21:10]); fail_count++;
          end
          if (out_tdata[29:22] !== m.disp) begin
            $error("disparity exp %0d got %0d", m.disp, $signed(out_tdata[29:22]));
            fail_count++;
          end
          if (out_tuser !== m.found) begin
            $error("found exp %0d got %0d", m.found, out_tuser); fail_count++;
          end
          if (out_tdata[45:30] !== m.score) begin
            $error("best_score exp %0d got %0d", m.score, $signed(out_tdata[45:30]));
            fail_count++;
          end
          if (out_tlast !== m.eof) begin
            $error("end_of_frame exp %0d got %0d", m.eof, out_tlast); fail_count++;
          end
          if (out_tdata[47:46] !== 2'b00) begin
            $error("pad bits exp 0 got %0d", out_tdata[47:46]); fail_count++;
          end
        end
      end
      if (hold_req && !hold_done && hold_cnt == 0) begin
        hold_cnt <= 5000;
        hold_done <= 1'b1;
        out_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_tready <= (hold_cnt == 1);
      end else if (calm) begin
        out_tready <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_tready <= (sink_gap == 1);
      end else if ($urandom_range(0, 3) == 0) begin
        sink_gap <= $urandom_range(1, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one pixel pair beat, held until taken
  task automatic send_pixel(input logic [7:0] lp, input logic [7:0] rp);
    in_tdata <= {rp, lp};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(lp, rp);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  img_w_q = val[10:0];
      REG_IMAGE_HEIGHT: img_h_q = val[12:0];
      REG_DISP_LOW:     dlo_q = val[6:0];
      REG_DISP_HIGH:    dhi_q = val[6:0];
      REG_THRESHOLD:    thr_q = val;
      default: ;
    endcase
  endtask

  // wait for all matches, then for the block to finish any window in flight
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic setup(input int w, input int h, input int lo, input int hi, input int thr);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_DISP_LOW, lo);
    write_reg(REG_DISP_HIGH, hi);
    write_reg(REG_THRESHOLD, thr);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // fill a frame: 0 noise, 1 right is left shifted by sh plus noise, 2 flat, 3 extremes
  task automatic build_frame(input int mode, input int sh);
    for (int r = 0; r < ARR; r++)
      for (int c = 0; c < ARR; c++) frame_l[r][c] = $urandom_range(0, 255);
    for (int r = 0; r < ARR; r++)
      for (int c = 0; c < ARR; c++) begin
        case (mode)
          1: frame_r[r][c] = (c + sh < ARR) ?
               frame_l[r][c + sh] ^ (($urandom_range(0, 3) == 0) ? 8'h01 : 8'h00) :
               $urandom_range(0, 255);
          2: begin frame_l[r][c] = 8'd100; frame_r[r][c] = 8'd100; end
          3: begin
            frame_l[r][c] = ((r + c) % 2) ? 8'hff : 8'h00;
            frame_r[r][c] = (c % 3 == 0) ? 8'h00 : 8'hff;
          end
          default: frame_r[r][c] = $urandom_range(0, 255);
        endcase
      end
  endtask

  task automatic send_frame(input int w, input int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        if (!calm && src_idle_en && $urandom_range(0, 7) == 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        send_pixel(frame_l[r][c], frame_r[r][c]);
      end
  endtask

  // corner cases at and near the smallest frame with a window
  task automatic test_directed();
    setup(9, 9, -4, 0, -32768);
    build_frame(1, 2); send_frame(9, 9);
    setup(9, 9, -4, 0, 0);
    build_frame(2, 0); send_frame(9, 9);
    setup(9, 9, -4, 0, 32767);
    build_frame(1, 1); send_frame(9, 9);
    setup(10, 9, -2, 63, -32768);
    build_frame(3, 0); send_frame(10, 9);
    setup(9, 10, 5, -5, -32768);
    build_frame(0, 0); send_frame(9, 10);
    setup(9, 9, -64, 63, -32768);
    build_frame(0, 0); send_frame(9, 9);
    setup(10, 10, -64, -60, -32768);
    build_frame(0, 0); send_frame(10, 10);
  endtask

  // frames too small for a window, and width/height below range
  task automatic test_tiny_frames();
    setup(0, 3, -4, 0, -32768);
    build_frame(0, 0); send_frame(1, 3);
    setup(5, 5, -4, 0, -32768);
    build_frame(0, 0); send_frame(5, 5);
    setup(9, 0, -4, 0, -32768);
    build_frame(0, 0); send_frame(9, 1);
  endtask

  // register extremes with no pixels sent
  task automatic test_register_extremes();
    setup(2047, 8191, 63, -64, 32767);
    setup(1024, 4096, -64, 63, -32768);
  endtask

  task automatic test_random_frames(input int pixel_goal);
    int sent, w, h, lo, hi, thr, mode;
    sent = 0;
    while (sent < pixel_goal) begin
      w = $urandom_range(9, 16);
      h = $urandom_range(9, 12);
      lo = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) - 64 : -$urandom_range(0, 12);
      hi = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) - 64 : lo + $urandom_range(0, 8);
      if (hi > 63) hi = 63;
      case ($urandom_range(0, 3))
        0: thr = -32768;
        1: thr = 0;
        2: thr = $urandom_range(20000, 32767);
        default: thr = $urandom_range(0, 65535);
      endcase
      mode = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 1;
      src_idle_en = ($urandom_range(0, 3) != 0);
      setup(w, h, lo, hi, thr);
      build_frame(mode, $urandom_range(0, 8));
      send_frame(w, h);
      sent += w * h;
    end
  endtask

  // receiver holds off while the sender keeps offering pixels
  task automatic test_backpressure();
    setup(12, 10, -6, 0, -32768);
    build_frame(1, 3);
    hold_req = 1'b1;
    send_frame(12, 10);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_tiny_frames();
    test_register_extremes();
    test_random_frames(300);
    test_backpressure();
    calm = 1'b1;
    test_random_frames(100);
    settle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
